// ===== sv/itp_pkg.sv =====
`timescale 1ns / 1ps

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DOTS     = 3'd1;
  localparam logic [2:0] ERR_STRAY    = 3'd2;
  localparam logic [2:0] ERR_DOUBLE   = 3'd3;
  localparam logic [2:0] ERR_TRAILING = 3'd4;
  localparam logic [2:0] ERR_UNBAL    = 3'd5;
  localparam logic [2:0] ERR_OVERFLOW = 3'd6;

  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pop;
    logic [7:0] wdata;
    logic [1:0] prec;
  } stk_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
    logic [7:0]       top;
    logic             top_is_open;
    logic             top_prec_ge;
  } stk_stat_t;

  function automatic logic [1:0] prec_of(logic [7:0] c);
    logic [1:0] p;
    case (c) inside
      CH_CARET:                  p = 2'd3;
      CH_STAR, CH_SLASH, CH_PCT: p = 2'd2;
      CH_PLUS, CH_MINUS:         p = 2'd1;
      default:                   p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

endpackage

// ===== sv/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps

// Infix to postfix converter, shunting-yard method with an 8-entry operator stack.
// Input channel: one ASCII character per word on symbol_i, is_last_i marks the
// final character of an expression. Output channel: one postfix character per
// word on out_char_o; error_code_o is nonzero on an error word (out_char_o zero,
// last_o high), and last_o marks the final word of an expression.
// One character is handled at a time; in_ready_o is high only while idle.
// An operator or a close paren takes longer the more stack entries it pops, and a
// final character also flushes the entries left on the stack; the sequencer walks
// the stack one entry per pop through a single precedence compare.
// An error caught on arrival goes straight to the error word; a later one first sends
// a word still held. A swallowed character is taken without leaving the idle state.
// Each word waits in an output register; when the receiver stalls the
// sequencer holds at the next word it has to send, so nothing is dropped.
// After an error the rest of the expression is swallowed with no output.
// Reset empties the stack and output register and clears all expression state.

module infix_to_postfix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLASS     = 4'd1;
  localparam logic [3:0] S_CLOSE_POP = 4'd2;
  localparam logic [3:0] S_OP_POP    = 4'd3;
  localparam logic [3:0] S_POP_SP    = 4'd4;
  localparam logic [3:0] S_END       = 4'd5;
  localparam logic [3:0] S_FLUSH_SP  = 4'd6;
  localparam logic [3:0] S_FLUSH_CH  = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;
  localparam logic [3:0] S_ERR       = 4'd9;

  logic [3:0] state_q, state_d;
  logic [7:0] sym_q, sym_d;
  logic       fin_q, fin_d;
  logic [1:0] prec_q, prec_d;
  logic       ret_op_q, ret_op_d;
  logic [2:0] err_q, err_d;
  logic [3:0] open_q, open_d;
  logic       lwo_q, lwo_d;
  logic [1:0] dot_q, dot_d;
  logic       disc_q, disc_d;
  logic       pend_valid_q, pend_valid_d;
  logic [7:0] pend_char_q, pend_char_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic [2:0] out_err_q, out_err_d;
  logic       out_last_q, out_last_d;

  logic       out_free, can_emit, accept;
  logic       emit_req, clear_all, out_load;
  logic [7:0] emit_char;

  itp_pkg::stk_cmd_t  stk_cmd;
  itp_pkg::stk_stat_t stk_stat;

  itp_stack u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .stat_o (stk_stat)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign error_code_o = out_err_q;
  assign last_o       = out_last_q;

  assign out_free = !out_valid_q || out_ready_i;
  // one word is held back so the final one can be tagged last
  assign can_emit = !pend_valid_q || out_free;

  always_comb begin
    state_d      = state_q;
    sym_d        = sym_q;
    fin_d        = fin_q;
    prec_d       = prec_q;
    ret_op_d     = ret_op_q;
    err_d        = err_q;
    open_d       = open_q;
    lwo_d        = lwo_q;
    dot_d        = dot_q;
    disc_d       = disc_q;
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    out_char_d   = pend_char_q;
    out_err_d    = itp_pkg::ERR_NONE;
    out_last_d   = 1'b0;
    out_load     = 1'b0;
    emit_req     = 1'b0;
    emit_char    = itp_pkg::CH_SPACE;
    clear_all    = 1'b0;
    stk_cmd      = '0;
    stk_cmd.prec = prec_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          sym_d = symbol_i;
          fin_d = is_last_i;
          if (disc_q) begin
            clear_all = is_last_i;
          end else begin
            state_d = S_CLASS;
          end
        end
      end

      S_CLASS: begin
        if (itp_pkg::is_alnum(sym_q)) begin
          if (can_emit) begin
            emit_req  = 1'b1;
            emit_char = sym_q;
            lwo_d     = 1'b0;
            state_d   = S_END;
          end
        end else if (sym_q == itp_pkg::CH_DOT) begin
          if (dot_q != 2'd0) begin
            dot_d   = 2'd2;
            err_d   = itp_pkg::ERR_DOTS;
            state_d = S_ERR;
          end else if (can_emit) begin
            dot_d     = 2'd1;
            emit_req  = 1'b1;
            emit_char = sym_q;
            lwo_d     = 1'b0;
            state_d   = S_END;
          end
        end else if (sym_q == itp_pkg::CH_LPAR) begin
          dot_d = 2'd0;
          if (stk_stat.full) begin
            err_d   = itp_pkg::ERR_OVERFLOW;
            state_d = S_ERR;
          end else if (can_emit) begin
            emit_req      = 1'b1;
            stk_cmd.push  = 1'b1;
            stk_cmd.wdata = sym_q;
            if (open_q != 4'hF) begin
              open_d = open_q + 4'd1;
            end
            lwo_d   = 1'b1;
            state_d = S_END;
          end
        end else if (sym_q == itp_pkg::CH_RPAR) begin
          dot_d = 2'd0;
          if (open_q == 4'd0) begin
            err_d   = itp_pkg::ERR_STRAY;
            state_d = S_ERR;
          end else if (can_emit) begin
            open_d   = open_q - 4'd1;
            emit_req = 1'b1;
            lwo_d    = 1'b0;
            ret_op_d = 1'b0;
            state_d  = S_CLOSE_POP;
          end
        end else begin
          dot_d = 2'd0;
          if (lwo_q) begin
            err_d   = itp_pkg::ERR_DOUBLE;
            state_d = S_ERR;
          end else if (can_emit) begin
            emit_req = 1'b1;
            prec_d   = itp_pkg::prec_of(sym_q);
            ret_op_d = 1'b1;
            state_d  = S_OP_POP;
          end
        end
      end

      S_CLOSE_POP: begin
        if (stk_stat.empty) begin
          state_d = S_END;
        end else if (stk_stat.top_is_open) begin
          stk_cmd.pop = 1'b1;
          state_d     = S_END;
        end else if (can_emit) begin
          emit_req    = 1'b1;
          emit_char   = stk_stat.top;
          stk_cmd.pop = 1'b1;
          state_d     = S_POP_SP;
        end
      end

      S_OP_POP: begin
        if (!stk_stat.empty && stk_stat.top_prec_ge) begin
          if (can_emit) begin
            emit_req    = 1'b1;
            emit_char   = stk_stat.top;
            stk_cmd.pop = 1'b1;
            state_d     = S_POP_SP;
          end
        end else if (stk_stat.full) begin
          err_d   = itp_pkg::ERR_OVERFLOW;
          state_d = S_ERR;
        end else begin
          stk_cmd.push  = 1'b1;
          stk_cmd.wdata = sym_q;
          lwo_d         = 1'b1;
          state_d       = S_END;
        end
      end

      S_POP_SP: begin
        if (can_emit) begin
          emit_req = 1'b1;
          state_d  = ret_op_q ? S_OP_POP : S_CLOSE_POP;
        end
      end

      S_END: begin
        if (!fin_q) begin
          state_d = S_DONE;
        end else if (lwo_q) begin
          err_d   = itp_pkg::ERR_TRAILING;
          state_d = S_ERR;
        end else if (open_q != 4'd0) begin
          err_d   = itp_pkg::ERR_UNBAL;
          state_d = S_ERR;
        end else if (!stk_stat.empty) begin
          state_d = S_FLUSH_SP;
        end else begin
          state_d = S_DONE;
        end
      end

      S_FLUSH_SP: begin
        if (can_emit) begin
          emit_req = 1'b1;
          state_d  = S_FLUSH_CH;
        end
      end

      S_FLUSH_CH: begin
        if (can_emit) begin
          emit_req    = 1'b1;
          emit_char   = stk_stat.top;
          stk_cmd.pop = 1'b1;
          state_d     = S_END;
        end
      end

      S_DONE: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_load   = 1'b1;
            out_last_d = fin_q;
          end
          pend_valid_d = 1'b0;
          clear_all    = fin_q;
          state_d      = S_IDLE;
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_q) begin
            // words of this character go out ahead of the error word
            pend_valid_d = 1'b0;
          end else begin
            out_char_d = itp_pkg::CH_NUL;
            out_err_d  = err_q;
            out_last_d = 1'b1;
            if (fin_q) begin
              clear_all = 1'b1;
            end else begin
              disc_d = 1'b1;
            end
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (emit_req) begin
      pend_valid_d = 1'b1;
      pend_char_d  = emit_char;
      if (pend_valid_q) begin
        out_load = 1'b1;
      end
    end

    if (clear_all) begin
      open_d        = 4'd0;
      lwo_d         = 1'b1;
      dot_d         = 2'd0;
      disc_d        = 1'b0;
      stk_cmd.clear = 1'b1;
    end

    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      open_q       <= 4'd0;
      lwo_q        <= 1'b1;
      dot_q        <= 2'd0;
      disc_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      open_q       <= open_d;
      lwo_q        <= lwo_d;
      dot_q        <= dot_d;
      disc_q       <= disc_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q       <= sym_d;
    fin_q       <= fin_d;
    prec_q      <= prec_d;
    ret_op_q    <= ret_op_d;
    err_q       <= err_d;
    pend_char_q <= pend_char_d;
    if (out_load) begin
      out_char_q <= out_char_d;
      out_err_q  <= out_err_d;
      out_last_q <= out_last_d;
    end
  end

  a_idle_no_held_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("held word left over while idle");

  a_error_word_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != itp_pkg::ERR_NONE |-> last_o && out_char_o == itp_pkg::CH_NUL)
    else $error("error word without last or with a character");

  a_stack_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_stat.count <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
    else $error("operator stack count beyond depth");

  a_discard_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q && state_q == S_IDLE |=> !out_load)
    else $error("output produced while discarding");

endmodule

// ===== sv/itp_stack.sv =====
`timescale 1ns / 1ps

module itp_stack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  itp_pkg::stk_cmd_t   cmd_i,
  output itp_pkg::stk_stat_t  stat_o
);

  logic [7:0]                 mem_q [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]  count_q, count_d;
  logic [itp_pkg::CNT_W-1:0]  top_cnt;
  logic                       empty, full;
  logic [7:0]                 top;

  assign empty   = (count_q == '0);
  assign full    = (count_q == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign top_cnt = count_q - itp_pkg::CNT_W'(1);
  assign top     = empty ? itp_pkg::CH_NUL : mem_q[top_cnt[itp_pkg::PTR_W-1:0]];

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push && !full) begin
      count_d = count_q + itp_pkg::CNT_W'(1);
    end else if (cmd_i.pop && !empty) begin
      count_d = top_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cmd_i.clear && cmd_i.push && !full) begin
      mem_q[count_q[itp_pkg::PTR_W-1:0]] <= cmd_i.wdata;
    end
  end

  // the one compare unit, reused on every pop iteration
  always_comb begin
    stat_o.count       = count_q;
    stat_o.empty       = empty;
    stat_o.full        = full;
    stat_o.top         = top;
    stat_o.top_is_open = (top == itp_pkg::CH_LPAR);
    stat_o.top_prec_ge = (itp_pkg::prec_of(top) >= cmd_i.prec);
  end

endmodule

// ===== tb/infix_to_postfix_converter_checker.sv =====
`timescale 1ns / 1ps

module infix_to_postfix_converter_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  symbol_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic [2:0]  error_code_i,
  input  logic        last_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned handled_o,
  output int unsigned words_o,
  output logic [7:0]  codes_seen_o
);

  localparam int unsigned MAX_WORDS = 33;

  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] code;
    logic       fin;
  } postfix_word_t;

  postfix_word_t postfix_q[$];
  postfix_word_t want;

  logic [7:0]  op_stack [itp_pkg::STACK_DEPTH];
  int unsigned sp;
  int unsigned opens;
  int unsigned dots;
  logic        after_op;
  logic        skipping;
  int unsigned step_words;

  int unsigned bad_cnt;
  int unsigned handled_cnt;
  int unsigned word_cnt;
  logic [7:0]  codes_seen;

  function automatic int unsigned rank(input logic [7:0] c);
    case (c)
      itp_pkg::CH_CARET:                                    return 3;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH, itp_pkg::CH_PCT: return 2;
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS:                  return 1;
      default:                                              return 0;
    endcase
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  task automatic clear_expr();
    sp       = 0;
    opens    = 0;
    dots     = 0;
    after_op = 1'b1;
    skipping = 1'b0;
  endtask

  task automatic put_word(input logic [7:0] ch, input logic [2:0] code, input logic fin);
    postfix_word_t w;
    w.ch   = ch;
    w.code = code;
    w.fin  = fin;
    if (step_words < MAX_WORDS) postfix_q.insert(postfix_q.size(), w);
    step_words++;
  endtask

  task automatic pop_op(output logic [7:0] c);
    sp--;
    c = op_stack[sp];
  endtask

  task automatic raise_error(input logic [2:0] code, input logic fin);
    put_word(itp_pkg::CH_NUL, code, 1'b1);
    if (fin) clear_expr();
    else skipping = 1'b1;
  endtask

  task automatic convert_char(input logic [7:0] c, input logic fin);
    logic [7:0] top;
    step_words = 0;
    if (skipping) begin
      // rest of a failed expression is swallowed until its final character
      if (fin) clear_expr();
      return;
    end
    if (is_operand(c)) begin
      put_word(c, itp_pkg::ERR_NONE, 1'b0);
      after_op = 1'b0;
    end else if (c == itp_pkg::CH_DOT) begin
      if (dots != 0) begin
        dots = 2;
        raise_error(itp_pkg::ERR_DOTS, fin);
        return;
      end
      dots = 1;
      put_word(c, itp_pkg::ERR_NONE, 1'b0);
      after_op = 1'b0;
    end else if (c == itp_pkg::CH_LPAR) begin
      dots = 0;
      if (sp >= itp_pkg::STACK_DEPTH) begin
        raise_error(itp_pkg::ERR_OVERFLOW, fin);
        return;
      end
      put_word(itp_pkg::CH_SPACE, itp_pkg::ERR_NONE, 1'b0);
      op_stack[sp] = c;
      sp++;
      if (opens < 15) opens++;
      after_op = 1'b1;
    end else if (c == itp_pkg::CH_RPAR) begin
      dots = 0;
      if (opens == 0) begin
        raise_error(itp_pkg::ERR_STRAY, fin);
        return;
      end
      opens--;
      put_word(itp_pkg::CH_SPACE, itp_pkg::ERR_NONE, 1'b0);
      while (sp > 0 && op_stack[sp-1] != itp_pkg::CH_LPAR) begin
        pop_op(top);
        put_word(top, itp_pkg::ERR_NONE, 1'b0);
        put_word(itp_pkg::CH_SPACE, itp_pkg::ERR_NONE, 1'b0);
      end
      // the open paren itself is dropped, if a rank-0 byte did not take it already
      if (sp > 0) pop_op(top);
      after_op = 1'b0;
    end else begin
      dots = 0;
      if (after_op) begin
        raise_error(itp_pkg::ERR_DOUBLE, fin);
        return;
      end
      put_word(itp_pkg::CH_SPACE, itp_pkg::ERR_NONE, 1'b0);
      while (sp > 0 && rank(op_stack[sp-1]) >= rank(c)) begin
        pop_op(top);
        put_word(top, itp_pkg::ERR_NONE, 1'b0);
        put_word(itp_pkg::CH_SPACE, itp_pkg::ERR_NONE, 1'b0);
      end
      if (sp >= itp_pkg::STACK_DEPTH) begin
        raise_error(itp_pkg::ERR_OVERFLOW, fin);
        return;
      end
      op_stack[sp] = c;
      sp++;
      after_op = 1'b1;
    end

    if (fin) begin
      if (after_op) begin
        raise_error(itp_pkg::ERR_TRAILING, 1'b1);
        return;
      end
      if (opens != 0) begin
        raise_error(itp_pkg::ERR_UNBAL, 1'b1);
        return;
      end
      while (sp > 0) begin
        pop_op(top);
        put_word(itp_pkg::CH_SPACE, itp_pkg::ERR_NONE, 1'b0);
        put_word(top, itp_pkg::ERR_NONE, 1'b0);
      end
      if (step_words > 0) postfix_q[postfix_q.size()-1].fin = 1'b1;
      clear_expr();
    end
  endtask

  task automatic check_word();
    word_cnt++;
    if (postfix_q.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("%0t: unexpected word char %h code %0d last %b",
                 $realtime, out_char_i, error_code_i, last_i);
      return;
    end
    want = postfix_q.pop_front();
    codes_seen[want.code] = 1'b1;
    if (want.ch !== out_char_i || want.code !== error_code_i || want.fin !== last_i) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("%0t: word mismatch: char %h/%h code %0d/%0d last %b/%b (expected/actual)",
                 $realtime, want.ch, out_char_i, want.code, error_code_i, want.fin, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_expr();
      postfix_q.delete();
      bad_cnt     = 0;
      handled_cnt = 0;
      word_cnt    = 0;
      codes_seen  = '0;
    end else begin
      // results are checked before the new character is predicted
      if (out_valid_i && out_ready_i) check_word();
      if (in_valid_i && in_ready_i) begin
        if (!skipping) handled_cnt++;
        convert_char(symbol_i, is_last_i);
      end
    end
    mismatches_o <= bad_cnt;
    pending_o    <= postfix_q.size();
    handled_o    <= handled_cnt;
    words_o      <= word_cnt;
    codes_seen_o <= codes_seen;
  end

endmodule

// ===== tb/infix_to_postfix_converter_tb.sv =====
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned TAIL_CYCLES  = 64;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] symbol_i    = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_char_o;
  logic [2:0] error_code_o;
  logic       last_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned handled;
  int unsigned words;
  logic [7:0]  codes_seen;

  int unsigned cycle_cnt  = 0;
  int unsigned stall_left = 0;
  int unsigned sent_cnt   = 0;
  logic        rx_calm    = 1'b0;
  logic        tx_calm    = 1'b0;
  logic [7:0]  expr_q[$];

  infix_to_postfix_converter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .symbol_i    (symbol_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .error_code_o(error_code_o),
    .last_o      (last_o)
  );

  infix_to_postfix_converter_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .symbol_i    (symbol_i),
    .is_last_i   (is_last_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_i  (out_char_o),
    .error_code_i(error_code_o),
    .last_i      (last_o),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .handled_o   (handled),
    .words_o     (words),
    .codes_seen_o(codes_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!rx_calm && $urandom_range(0, 99) < 25) stall_left <= idle_len();
    end
  end

  // called right after a rising edge; returns right after the edge that took the word
  task automatic send_sym(input logic [7:0] sym, input logic fin);
    int unsigned gap;
    gap = (!tx_calm && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    is_last_i  <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_sym(s[i], i == s.len() - 1);
  endtask

  task automatic send_expr();
    int i;
    for (i = 0; i < expr_q.size(); i++) send_sym(expr_q[i], i == expr_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic append_char(input logic [7:0] c);
    expr_q.insert(expr_q.size(), c);
  endtask

  function automatic logic [7:0] operand_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h30, 8'h39));
      1:       return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] operator_char();
    case ($urandom_range(0, 5))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_STAR;
      3:       return itp_pkg::CH_SLASH;
      4:       return itp_pkg::CH_PCT;
      default: return itp_pkg::CH_CARET;
    endcase
  endfunction

  task automatic build_wellformed();
    int unsigned terms, nest_cap, depth, t, k, n;
    logic        deep;
    expr_q.delete();
    terms    = $urandom_range(1, 6);
    deep     = ($urandom_range(0, 7) == 0);
    nest_cap = deep ? 10 : 3;
    depth    = 0;
    for (t = 0; t < terms; t++) begin
      while (depth < nest_cap && (deep ? $urandom_range(0, 2) != 0 : $urandom_range(0, 2) == 0))
      begin
        append_char(itp_pkg::CH_LPAR);
        depth++;
      end
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) append_char(operand_char());
      if ($urandom_range(0, 4) == 0) begin
        append_char(itp_pkg::CH_DOT);
        append_char(operand_char());
      end
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        append_char(itp_pkg::CH_RPAR);
        depth--;
      end
      if (t != terms - 1) append_char(operator_char());
    end
    while (depth > 0) begin
      append_char(itp_pkg::CH_RPAR);
      depth--;
    end
  endtask

  task automatic build_random_expr();
    int unsigned r, n, k;
    r = $urandom_range(0, 99);
    build_wellformed();
    if (r < 70) begin
      // clean expression, nothing to add
    end else if (r < 78) begin
      expr_q[$urandom_range(0, expr_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (r < 84) begin
      append_char(operator_char());
    end else if (r < 88) begin
      expr_q.push_front(itp_pkg::CH_LPAR);
    end else if (r < 92) begin
      append_char(itp_pkg::CH_RPAR);
    end else if (r < 95) begin
      append_char(itp_pkg::CH_DOT);
      append_char(operand_char());
      append_char(itp_pkg::CH_DOT);
    end else begin
      expr_q.delete();
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++) append_char(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned base;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // second decimal point on the final character
    send_text(".5.");
    // close with nothing open
    send_text(")");
    // two operators in a row, then the rest of the expression dropped
    send_text("a*-b");
    send_text("a*/");
    // trailing operator, here the all-zero byte
    send_sym("z", 1'b0);
    send_sym(itp_pkg::CH_NUL, 1'b1);
    // nine opens overflow the stack
    send_text("(((((((((");
    // open left at the end
    send_text("(a");
    // rank-0 byte takes the open paren, close then empties the stack
    send_sym(itp_pkg::CH_LPAR, 1'b0);
    send_sym("a", 1'b0);
    send_sym(8'hFF, 1'b0);
    send_sym("b", 1'b0);
    send_sym(itp_pkg::CH_RPAR, 1'b1);
    send_text("9^Z%0");
    wait_drained();

    base = handled;
    while (handled - base < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm <= ($urandom_range(0, 4) == 0);
      build_random_expr();
      send_expr();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run covered %0d characters (%0d handled), %0d postfix words checked",
             sent_cnt, handled, words);
    $display("error codes reached, one bit per code: %b", codes_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/itp_pkg.sv
sv/itp_stack.sv
sv/infix_to_postfix_converter.sv
tb/infix_to_postfix_converter_checker.sv
tb/infix_to_postfix_converter_tb.sv
